// ===== src/tscb_pkg.sv =====
package tscb_pkg;

  localparam int unsigned TILE_SIZE_DEF  = 32;
  localparam int unsigned MAX_SCREEN_DEF = 4096;
  localparam int unsigned COORD_BITS_DEF = 14;

  localparam int unsigned CFG_W   = 13;
  localparam int unsigned AREA_W  = 31;
  localparam int unsigned BOX_W   = 12;
  localparam int unsigned TILES_W = 8;

  localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

  typedef enum logic [2:0] {
    ST_DRAW,
    ST_ZERO,
    ST_FRONT,
    ST_BACK,
    ST_OFF
  } status_e;

  typedef enum logic [2:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_FRONT_CW,
    CFG_CULL_FRONT,
    CFG_CULL_BACK
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             front_cw;
    logic             cull_front;
    logic             cull_back;
  } cfg_t;

endpackage

// ===== src/tscb_tri_if.sv =====
interface tscb_tri_if #(
  parameter int unsigned COORD_BITS = tscb_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] vert0_x;
  logic signed [COORD_BITS-1:0] vert0_y;
  logic signed [COORD_BITS-1:0] vert1_x;
  logic signed [COORD_BITS-1:0] vert1_y;
  logic signed [COORD_BITS-1:0] vert2_x;
  logic signed [COORD_BITS-1:0] vert2_y;

  modport source (
    output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
    input  ready
  );

  modport sink (
    input  valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x, vert2_y,
    output ready
  );
endinterface

// ===== src/tscb_res_if.sv =====
interface tscb_res_if;
  logic                                   valid;
  logic                                   ready;
  tscb_pkg::status_e                      status;
  logic                                   negate_bary;
  logic signed [tscb_pkg::AREA_W-1:0]     double_area;
  logic        [tscb_pkg::BOX_W-1:0]      box_min_x;
  logic        [tscb_pkg::BOX_W-1:0]      box_min_y;
  logic        [tscb_pkg::BOX_W-1:0]      box_max_x;
  logic        [tscb_pkg::BOX_W-1:0]      box_max_y;
  logic        [tscb_pkg::TILES_W-1:0]    tiles_x;
  logic        [tscb_pkg::TILES_W-1:0]    tiles_y;

  modport source (
    output valid, status, negate_bary, double_area,
           box_min_x, box_min_y, box_max_x, box_max_y, tiles_x, tiles_y,
    input  ready
  );

  modport sink (
    input  valid, status, negate_bary, double_area,
           box_min_x, box_min_y, box_max_x, box_max_y, tiles_x, tiles_y,
    output ready
  );
endinterface

// ===== src/triangle_setup_cull_box_unit.sv =====
// Triangle setup: area, face cull and screen-clamped tile box.
// Throughput: one triangle per cycle; the five stages hold together while the
// output waits, and the last stage register is the output register.
// Reset clears all stage valid bits and loads 640x480, counter-clockwise front,
// no culling into the configuration registers.
module triangle_setup_cull_box_unit #(
  parameter int unsigned TILE_SIZE  = tscb_pkg::TILE_SIZE_DEF,
  parameter int unsigned MAX_SCREEN = tscb_pkg::MAX_SCREEN_DEF,
  parameter int unsigned COORD_BITS = tscb_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [2:0]                  cfg_idx_i,
  input  logic [tscb_pkg::CFG_W-1:0]  cfg_data_i,
  tscb_tri_if.sink                    tri_i,
  tscb_res_if.source                  res_o
);
  import tscb_pkg::*;

  localparam int unsigned SPAN_W = $clog2(MAX_SCREEN);

  cfg_t cfg_q;

  logic                            adv;
  logic                            v2, v3;
  logic signed [2*COORD_BITS+1:0]  prod_a, prod_b;
  logic signed [COORD_BITS-1:0]    min_x, max_x, min_y, max_y;
  status_e                         status3;
  logic                            neg3;
  logic signed [AREA_W-1:0]        area3;
  logic [BOX_W-1:0]                bx0, by0, bx1, by1;
  logic [SPAN_W-1:0]               span_x, span_y;

  // advance the whole pipeline unless a finished result is held
  assign adv         = !res_o.valid || res_o.ready;
  assign tri_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width      <= WIDTH_RST;
      cfg_q.height     <= HEIGHT_RST;
      cfg_q.front_cw   <= 1'b0;
      cfg_q.cull_front <= 1'b0;
      cfg_q.cull_back  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_WIDTH:      cfg_q.width      <= cfg_data_i;
        CFG_HEIGHT:     cfg_q.height     <= cfg_data_i;
        CFG_FRONT_CW:   cfg_q.front_cw   <= cfg_data_i[0];
        CFG_CULL_FRONT: cfg_q.cull_front <= cfg_data_i[0];
        CFG_CULL_BACK:  cfg_q.cull_back  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  tscb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (tri_i.valid),
    .x0_i     (tri_i.vert0_x),
    .y0_i     (tri_i.vert0_y),
    .x1_i     (tri_i.vert1_x),
    .y1_i     (tri_i.vert1_y),
    .x2_i     (tri_i.vert2_x),
    .y2_i     (tri_i.vert2_y),
    .valid_o  (v2),
    .prod_a_o (prod_a),
    .prod_b_o (prod_b),
    .min_x_o  (min_x),
    .max_x_o  (max_x),
    .min_y_o  (min_y),
    .max_y_o  (max_y)
  );

  tscb_classify #(
    .COORD_BITS (COORD_BITS),
    .MAX_SCREEN (MAX_SCREEN)
  ) u_classify (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (v2),
    .cfg_i       (cfg_q),
    .prod_a_i    (prod_a),
    .prod_b_i    (prod_b),
    .min_x_i     (min_x),
    .max_x_i     (max_x),
    .min_y_i     (min_y),
    .max_y_i     (max_y),
    .valid_o     (v3),
    .status_o    (status3),
    .neg_o       (neg3),
    .area_o      (area3),
    .box_min_x_o (bx0),
    .box_min_y_o (by0),
    .box_max_x_o (bx1),
    .box_max_y_o (by1),
    .span_x_o    (span_x),
    .span_y_o    (span_y)
  );

  tscb_tiles #(
    .TILE_SIZE  (TILE_SIZE),
    .MAX_SCREEN (MAX_SCREEN)
  ) u_tiles (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (v3),
    .status_i    (status3),
    .neg_i       (neg3),
    .area_i      (area3),
    .box_min_x_i (bx0),
    .box_min_y_i (by0),
    .box_max_x_i (bx1),
    .box_max_y_i (by1),
    .span_x_i    (span_x),
    .span_y_i    (span_y),
    .valid_o     (res_o.valid),
    .status_o    (res_o.status),
    .neg_o       (res_o.negate_bary),
    .area_o      (res_o.double_area),
    .box_min_x_o (res_o.box_min_x),
    .box_min_y_o (res_o.box_min_y),
    .box_max_x_o (res_o.box_max_x),
    .box_max_y_o (res_o.box_max_y),
    .tiles_x_o   (res_o.tiles_x),
    .tiles_y_o   (res_o.tiles_y)
  );

endmodule

// ===== src/tscb_front.sv =====
module tscb_front #(
  parameter int unsigned COORD_BITS = tscb_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           valid_i,
  input  logic signed [COORD_BITS-1:0]   x0_i,
  input  logic signed [COORD_BITS-1:0]   y0_i,
  input  logic signed [COORD_BITS-1:0]   x1_i,
  input  logic signed [COORD_BITS-1:0]   y1_i,
  input  logic signed [COORD_BITS-1:0]   x2_i,
  input  logic signed [COORD_BITS-1:0]   y2_i,
  output logic                           valid_o,
  output logic signed [2*COORD_BITS+1:0] prod_a_o,
  output logic signed [2*COORD_BITS+1:0] prod_b_o,
  output logic signed [COORD_BITS-1:0]   min_x_o,
  output logic signed [COORD_BITS-1:0]   max_x_o,
  output logic signed [COORD_BITS-1:0]   min_y_o,
  output logic signed [COORD_BITS-1:0]   max_y_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;

  logic                         v1_q, v2_q;
  logic signed [DW-1:0]         d1x_d, d2y_d, d1y_d, d2x_d;
  logic signed [DW-1:0]         d1x_q, d2y_q, d1y_q, d2x_q;
  logic signed [COORD_BITS-1:0] mnx_d, mxx_d, mny_d, mxy_d;
  logic signed [COORD_BITS-1:0] mnx1_q, mxx1_q, mny1_q, mxy1_q;
  logic signed [COORD_BITS-1:0] mnx2_q, mxx2_q, mny2_q, mxy2_q;
  logic signed [PW-1:0]         prod_a_d, prod_b_d;
  logic signed [PW-1:0]         prod_a_q, prod_b_q;

  // edge vectors from vertex 0
  always_comb begin
    d1x_d = DW'(x1_i) - DW'(x0_i);
    d2y_d = DW'(y2_i) - DW'(y0_i);
    d1y_d = DW'(y1_i) - DW'(y0_i);
    d2x_d = DW'(x2_i) - DW'(x0_i);
  end

  always_comb begin
    mnx_d = (x1_i < x0_i) ? x1_i : x0_i;
    if (x2_i < mnx_d) mnx_d = x2_i;
    mxx_d = (x1_i > x0_i) ? x1_i : x0_i;
    if (x2_i > mxx_d) mxx_d = x2_i;
    mny_d = (y1_i < y0_i) ? y1_i : y0_i;
    if (y2_i < mny_d) mny_d = y2_i;
    mxy_d = (y1_i > y0_i) ? y1_i : y0_i;
    if (y2_i > mxy_d) mxy_d = y2_i;
  end

  always_comb begin
    prod_a_d = PW'(d1x_q) * PW'(d2y_q);
    prod_b_d = PW'(d1y_q) * PW'(d2x_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d1x_q    <= d1x_d;
      d2y_q    <= d2y_d;
      d1y_q    <= d1y_d;
      d2x_q    <= d2x_d;
      mnx1_q   <= mnx_d;
      mxx1_q   <= mxx_d;
      mny1_q   <= mny_d;
      mxy1_q   <= mxy_d;
      prod_a_q <= prod_a_d;
      prod_b_q <= prod_b_d;
      mnx2_q   <= mnx1_q;
      mxx2_q   <= mxx1_q;
      mny2_q   <= mny1_q;
      mxy2_q   <= mxy1_q;
    end
  end

  assign valid_o  = v2_q;
  assign prod_a_o = prod_a_q;
  assign prod_b_o = prod_b_q;
  assign min_x_o  = mnx2_q;
  assign max_x_o  = mxx2_q;
  assign min_y_o  = mny2_q;
  assign max_y_o  = mxy2_q;

endmodule

// ===== src/tscb_classify.sv =====
module tscb_classify #(
  parameter int unsigned COORD_BITS = tscb_pkg::COORD_BITS_DEF,
  parameter int unsigned MAX_SCREEN = tscb_pkg::MAX_SCREEN_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  tscb_pkg::cfg_t                       cfg_i,
  input  logic signed [2*COORD_BITS+1:0]       prod_a_i,
  input  logic signed [2*COORD_BITS+1:0]       prod_b_i,
  input  logic signed [COORD_BITS-1:0]         min_x_i,
  input  logic signed [COORD_BITS-1:0]         max_x_i,
  input  logic signed [COORD_BITS-1:0]         min_y_i,
  input  logic signed [COORD_BITS-1:0]         max_y_i,
  output logic                                 valid_o,
  output tscb_pkg::status_e                    status_o,
  output logic                                 neg_o,
  output logic signed [tscb_pkg::AREA_W-1:0]   area_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_min_x_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_min_y_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_max_x_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_max_y_o,
  output logic [$clog2(MAX_SCREEN)-1:0]        span_x_o,
  output logic [$clog2(MAX_SCREEN)-1:0]        span_y_o
);
  import tscb_pkg::*;

  localparam int unsigned PW     = 2 * COORD_BITS + 2;
  localparam int unsigned AW     = PW + 1;
  localparam int unsigned AXW    = (AW > AREA_W) ? AW : AREA_W;
  localparam int unsigned SB     = $clog2(MAX_SCREEN + 1);
  localparam int unsigned CMPW   = ((COORD_BITS > SB) ? COORD_BITS : SB) + 2;
  localparam int unsigned SPAN_W = $clog2(MAX_SCREEN);

  localparam logic signed [CMPW-1:0] MAX_S = CMPW'(MAX_SCREEN);
  localparam logic signed [CMPW-1:0] ONE_S = CMPW'(1);
  localparam logic signed [CMPW-1:0] ZERO_S = '0;

  logic signed [AW-1:0]   area;
  logic signed [AXW-1:0]  area_x;
  logic                   front, back;
  logic signed [CMPW-1:0] ext_w, ext_h, last_x, last_y;
  logic signed [CMPW-1:0] mnx, mxx, mny, mxy, span_x, span_y;
  logic                   off;

  logic                   v_q;
  status_e                status_d, status_q;
  logic                   neg_d, neg_q;
  logic signed [AREA_W-1:0] area_q;
  logic [BOX_W-1:0]       bx0_d, by0_d, bx1_d, by1_d;
  logic [BOX_W-1:0]       bx0_q, by0_q, bx1_q, by1_q;
  logic [SPAN_W-1:0]      spx_d, spy_d, spx_q, spy_q;

  always_comb begin
    area   = AW'(prod_a_i) - AW'(prod_b_i);
    area_x = AXW'(area);
    // positive unflipped area is front facing unless clockwise is front
    front  = cfg_i.front_cw ? (area < 0) : (area > 0);
    back   = cfg_i.front_cw ? (area > 0) : (area < 0);
  end

  always_comb begin
    ext_w = CMPW'($signed({1'b0, cfg_i.width}));
    ext_h = CMPW'($signed({1'b0, cfg_i.height}));
    priority if (ext_w == ZERO_S) last_x = ZERO_S;
    else if (ext_w > MAX_S)        last_x = MAX_S - ONE_S;
    else                           last_x = ext_w - ONE_S;
    priority if (ext_h == ZERO_S) last_y = ZERO_S;
    else if (ext_h > MAX_S)        last_y = MAX_S - ONE_S;
    else                           last_y = ext_h - ONE_S;

    mnx = CMPW'(min_x_i);
    mny = CMPW'(min_y_i);
    mxx = CMPW'(max_x_i);
    mxy = CMPW'(max_y_i);
    if (mnx < ZERO_S) mnx = ZERO_S;
    if (mny < ZERO_S) mny = ZERO_S;
    if (mxx > last_x) mxx = last_x;
    if (mxy > last_y) mxy = last_y;
    off    = (mnx > mxx) || (mny > mxy);
    span_x = mxx - mnx;
    span_y = mxy - mny;
  end

  always_comb begin
    neg_d = 1'b0;
    bx0_d = '0;
    by0_d = '0;
    bx1_d = '0;
    by1_d = '0;
    spx_d = '0;
    spy_d = '0;
    priority if (area == '0) begin
      status_d = ST_ZERO;
    end else if (front && cfg_i.cull_front) begin
      status_d = ST_FRONT;
    end else if (back && cfg_i.cull_back) begin
      status_d = ST_BACK;
    end else if (off) begin
      status_d = ST_OFF;
      neg_d    = area < 0;
    end else begin
      status_d = ST_DRAW;
      neg_d    = area < 0;
      bx0_d    = mnx[BOX_W-1:0];
      by0_d    = mny[BOX_W-1:0];
      bx1_d    = mxx[BOX_W-1:0];
      by1_d    = mxy[BOX_W-1:0];
      spx_d    = span_x[SPAN_W-1:0];
      spy_d    = span_y[SPAN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      status_q <= status_d;
      neg_q    <= neg_d;
      area_q   <= area_x[AREA_W-1:0];
      bx0_q    <= bx0_d;
      by0_q    <= by0_d;
      bx1_q    <= bx1_d;
      by1_q    <= by1_d;
      spx_q    <= spx_d;
      spy_q    <= spy_d;
    end
  end

  assign valid_o     = v_q;
  assign status_o    = status_q;
  assign neg_o       = neg_q;
  assign area_o      = area_q;
  assign box_min_x_o = bx0_q;
  assign box_min_y_o = by0_q;
  assign box_max_x_o = bx1_q;
  assign box_max_y_o = by1_q;
  assign span_x_o    = spx_q;
  assign span_y_o    = spy_q;

endmodule

// ===== src/tscb_tiles.sv =====
module tscb_tiles #(
  parameter int unsigned TILE_SIZE  = tscb_pkg::TILE_SIZE_DEF,
  parameter int unsigned MAX_SCREEN = tscb_pkg::MAX_SCREEN_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 adv_i,
  input  logic                                 valid_i,
  input  tscb_pkg::status_e                    status_i,
  input  logic                                 neg_i,
  input  logic signed [tscb_pkg::AREA_W-1:0]   area_i,
  input  logic [tscb_pkg::BOX_W-1:0]           box_min_x_i,
  input  logic [tscb_pkg::BOX_W-1:0]           box_min_y_i,
  input  logic [tscb_pkg::BOX_W-1:0]           box_max_x_i,
  input  logic [tscb_pkg::BOX_W-1:0]           box_max_y_i,
  input  logic [$clog2(MAX_SCREEN)-1:0]        span_x_i,
  input  logic [$clog2(MAX_SCREEN)-1:0]        span_y_i,
  output logic                                 valid_o,
  output tscb_pkg::status_e                    status_o,
  output logic                                 neg_o,
  output logic signed [tscb_pkg::AREA_W-1:0]   area_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_min_x_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_min_y_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_max_x_o,
  output logic [tscb_pkg::BOX_W-1:0]           box_max_y_o,
  output logic [tscb_pkg::TILES_W-1:0]         tiles_x_o,
  output logic [tscb_pkg::TILES_W-1:0]         tiles_y_o
);
  import tscb_pkg::*;

  // span / TILE_SIZE as span * ceil(2^K / TILE_SIZE) >> K, exact for all spans
  localparam int unsigned SPAN_W = $clog2(MAX_SCREEN);
  localparam int unsigned K      = SPAN_W + $clog2(TILE_SIZE);
  localparam int unsigned RECIP  = ((1 << K) + TILE_SIZE - 1) / TILE_SIZE;
  localparam int unsigned RW     = $clog2(RECIP + 1);
  localparam int unsigned PRW    = SPAN_W + RW;
  localparam int unsigned QW     = PRW - K;

  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);

  logic                     v4_q, v5_q;
  logic [PRW-1:0]           px_d, py_d, px_q, py_q;
  status_e                  st4_q, st5_q;
  logic                     neg4_q, neg5_q;
  logic signed [AREA_W-1:0] area4_q, area5_q;
  logic [BOX_W-1:0]         bx04_q, by04_q, bx14_q, by14_q;
  logic [BOX_W-1:0]         bx05_q, by05_q, bx15_q, by15_q;
  logic [QW:0]              tsx, tsy;
  logic [TILES_W-1:0]       tx_d, ty_d, tx_q, ty_q;

  always_comb begin
    px_d = PRW'(span_x_i) * PRW'(RECIP_C);
    py_d = PRW'(span_y_i) * PRW'(RECIP_C);
  end

  always_comb begin
    tsx = (QW+1)'(px_q[PRW-1:K]) + (QW+1)'(1);
    tsy = (QW+1)'(py_q[PRW-1:K]) + (QW+1)'(1);
    tx_d = '0;
    ty_d = '0;
    if (st4_q == ST_DRAW) begin
      tx_d = TILES_W'(tsx);
      ty_d = TILES_W'(tsy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (adv_i) begin
      v4_q <= valid_i;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      px_q    <= px_d;
      py_q    <= py_d;
      st4_q   <= status_i;
      neg4_q  <= neg_i;
      area4_q <= area_i;
      bx04_q  <= box_min_x_i;
      by04_q  <= box_min_y_i;
      bx14_q  <= box_max_x_i;
      by14_q  <= box_max_y_i;
      st5_q   <= st4_q;
      neg5_q  <= neg4_q;
      area5_q <= area4_q;
      bx05_q  <= bx04_q;
      by05_q  <= by04_q;
      bx15_q  <= bx14_q;
      by15_q  <= by14_q;
      tx_q    <= tx_d;
      ty_q    <= ty_d;
    end
  end

  assign valid_o     = v5_q;
  assign status_o    = st5_q;
  assign neg_o       = neg5_q;
  assign area_o      = area5_q;
  assign box_min_x_o = bx05_q;
  assign box_min_y_o = by05_q;
  assign box_max_x_o = bx15_q;
  assign box_max_y_o = by15_q;
  assign tiles_x_o   = tx_q;
  assign tiles_y_o   = ty_q;

endmodule
